[rtl/tslt_pkg.sv]
package tslt_pkg;

  localparam int SCORE_W     = 32;
  localparam int IDX_FIELD_W = 16;
  localparam int CFG_CNT_W   = 6;

  // per-cell control, decoded anew each cycle; at most one member is set
  typedef struct packed {
    logic rotate;     // take the entry of the rotate source (read-out)
    logic shift;      // take the entry of the left neighbor (insertion)
    logic load_new;   // take the offered entry
  } cell_ctrl_t;

endpackage

[rtl/tslt_cell.sv]
module tslt_cell #(
  parameter int IDX_W = 16
) (
  input  logic                                clk,
  input  tslt_pkg::cell_ctrl_t                ctrl,
  input  logic signed [tslt_pkg::SCORE_W-1:0] new_score,
  input  logic [IDX_W-1:0]                    new_query,
  input  logic [IDX_W-1:0]                    new_target,
  input  logic signed [tslt_pkg::SCORE_W-1:0] left_score,
  input  logic [IDX_W-1:0]                    left_query,
  input  logic [IDX_W-1:0]                    left_target,
  input  logic signed [tslt_pkg::SCORE_W-1:0] rot_score,
  input  logic [IDX_W-1:0]                    rot_query,
  input  logic [IDX_W-1:0]                    rot_target,
  input  logic signed [tslt_pkg::SCORE_W-1:0] threshold,
  output logic signed [tslt_pkg::SCORE_W-1:0] score,
  output logic [IDX_W-1:0]                    query,
  output logic [IDX_W-1:0]                    target,
  output logic                                le_new,
  output logic                                ge_thr
);
  import tslt_pkg::*;

  assign le_new = (score <= new_score);
  assign ge_thr = (score >= threshold);

  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      score  <= rot_score;
      query  <= rot_query;
      target <= rot_target;
    end else if (ctrl.shift) begin
      score  <= left_score;
      query  <= left_query;
      target <= left_target;
    end else if (ctrl.load_new) begin
      score  <= new_score;
      query  <= new_query;
      target <= new_target;
    end
  end

endmodule

[rtl/top_score_list_with_threshold.sv]
// Keeps up to LIST_DEPTH (score, query, target) entries sorted by descending signed
// Q16.16 score in a row of cells. For a kept offer, in the accept cycle every cell compares
// its score with the offer and the row shifts to open a slot, and in the next cycle the
// threshold trim sets the new length and the last kept score; then the next item is taken.
// A dropped offer skips the trim. A read is accepted and then emits one entry a cycle while
// the receiver is ready,
// max(entry_count, 1) results, as the row rotates past cell 0, so that the row is back
// in order when the last result leaves; an empty list gives one result with tuser 0.
// The output register lets the next item be accepted while the final result waits.
module top_score_list_with_threshold #(
  parameter int LIST_DEPTH = 32,
  parameter int INDEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // score[31:0], query_index[47:32], target_index[63:48]
  input  logic        s_tuser,   // op: 0 offer, 1 read out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // entry_score[31:0], entry_query[47:32], entry_target[63:48]
  output logic        m_tuser,   // entry_valid
  output logic        m_tlast,   // last_entry
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tslt_pkg::*;

  localparam int IDX_W = (INDEX_BITS < IDX_FIELD_W) ? INDEX_BITS : IDX_FIELD_W;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TRIM = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_AT_LEAST  = 2'd1;
  localparam logic [1:0] REG_AT_MOST   = 2'd2;
  localparam logic [1:0] REG_SELF_SIM  = 2'd3;

  localparam logic OP_READ = 1'b1;

  // configuration registers
  logic signed [SCORE_W-1:0] score_threshold;
  logic [CFG_CNT_W-1:0]      keep_at_least;
  logic [CFG_CNT_W-1:0]      keep_at_most;
  logic                      self_similar;

  logic [1:0]                state;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          rd_idx;
  logic signed [SCORE_W-1:0] last_kept;

  logic signed [SCORE_W-1:0] m_score;
  logic [IDX_FIELD_W-1:0]    m_query;
  logic [IDX_FIELD_W-1:0]    m_target;

  // row of cells
  logic signed [SCORE_W-1:0] c_score  [LIST_DEPTH];
  logic [IDX_W-1:0]          c_query  [LIST_DEPTH];
  logic [IDX_W-1:0]          c_target [LIST_DEPTH];
  logic                      c_le     [LIST_DEPTH];
  logic                      c_ge     [LIST_DEPTH];
  cell_ctrl_t                c_ctrl   [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]     flag;
  logic [LIST_DEPTH-1:0]     keep;

  logic signed [SCORE_W-1:0] in_score;
  logic [IDX_W-1:0]          in_query;
  logic [IDX_W-1:0]          in_target;
  logic                      accept;
  logic                      drop;
  logic                      do_offer;
  logic                      any_flag;
  logic                      load_out;
  logic                      rotate;
  logic                      rd_last;

  logic [CMP_W-1:0]          lim;
  logic [CMP_W-1:0]          cnt_inc;
  logic [CMP_W-1:0]          cnt_mid;
  logic [CMP_W-1:0]          cnt_ge;
  logic [CMP_W-1:0]          cnt_trim;
  logic signed [SCORE_W-1:0] trim_last;

  assign in_score  = s_tdata[31:0];
  assign in_query  = s_tdata[32 +: IDX_W];
  assign in_target = s_tdata[48 +: IDX_W];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign drop = (self_similar && (in_query <= in_target)) ||
                ((in_score < score_threshold) && (in_score <= last_kept) &&
                 (CMP_W'(count) >= CMP_W'(keep_at_least)));
  assign do_offer = accept && (s_tuser != OP_READ) && !drop;

  assign load_out = !m_tvalid || m_tready;
  assign rotate   = (state == ST_READ) && load_out && (count != '0);
  assign rd_last  = (rd_idx + CNT_W'(1) == count);

  // insertion point: first kept entry whose score is not above the offer
  always_comb begin
    for (int k = 0; k < LIST_DEPTH; k++) begin
      flag[k] = (CNT_W'(k) < count) && c_le[k];
    end
    any_flag = |flag;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      c_ctrl[k].rotate   = rotate;
      c_ctrl[k].shift    = do_offer && (k > 0) && flag[(k > 0) ? k - 1 : 0];
      c_ctrl[k].load_new = do_offer &&
                           ((flag[k] && ((k == 0) || !flag[(k > 0) ? k - 1 : 0])) ||
                            (!any_flag && (CNT_W'(k) == count)));
    end
  end

  // length after the insertion step, cut to keep_at_most
  always_comb begin
    lim     = (CMP_W'(keep_at_most) < CMP_W'(LIST_DEPTH)) ? CMP_W'(keep_at_most)
                                                          : CMP_W'(LIST_DEPTH);
    cnt_inc = (count < CNT_W'(LIST_DEPTH)) ? CMP_W'(count) + CMP_W'(1) : CMP_W'(count);
    cnt_mid = (cnt_inc > lim) ? lim : cnt_inc;
  end

  // threshold trim: kept entries at or above threshold form a prefix; cut to its end, but not below keep_at_least
  always_comb begin
    for (int k = 0; k < LIST_DEPTH; k++) begin
      keep[k] = (CNT_W'(k) < count) && c_ge[k];
    end
    cnt_ge = '0;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      if (keep[k] && ((k == LIST_DEPTH - 1) || !keep[(k < LIST_DEPTH - 1) ? k + 1 : k])) begin
        cnt_ge = cnt_ge | CMP_W'(k + 1);
      end
    end
    if (CMP_W'(count) <= CMP_W'(keep_at_least)) begin
      cnt_trim = CMP_W'(count);
    end else if (CMP_W'(keep_at_least) > cnt_ge) begin
      cnt_trim = CMP_W'(keep_at_least);
    end else begin
      cnt_trim = cnt_ge;
    end
    trim_last = '0;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      if (CMP_W'(k + 1) == cnt_trim) begin
        trim_last = trim_last | c_score[k];
      end
    end
  end

  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    localparam int LK = (k > 0) ? k - 1 : 0;
    localparam int RK = (k < LIST_DEPTH - 1) ? k + 1 : 0;
    logic rot_wrap;
    assign rot_wrap = (CNT_W'(k + 1) == count);

    tslt_cell #(.IDX_W(IDX_W)) u_cell (
      .clk        (clk),
      .ctrl       (c_ctrl[k]),
      .new_score  (in_score),
      .new_query  (in_query),
      .new_target (in_target),
      .left_score (c_score[LK]),
      .left_query (c_query[LK]),
      .left_target(c_target[LK]),
      .rot_score  (rot_wrap ? c_score[0]  : c_score[RK]),
      .rot_query  (rot_wrap ? c_query[0]  : c_query[RK]),
      .rot_target (rot_wrap ? c_target[0] : c_target[RK]),
      .threshold  (score_threshold),
      .score      (c_score[k]),
      .query      (c_query[k]),
      .target     (c_target[k]),
      .le_new     (c_le[k]),
      .ge_thr     (c_ge[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_threshold <= {1'b1, {(SCORE_W-1){1'b0}}};
      keep_at_least   <= CFG_CNT_W'(1);
      keep_at_most    <= CFG_CNT_W'(32);
      self_similar    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: score_threshold <= cfg_data;
        REG_AT_LEAST:  keep_at_least   <= cfg_data[CFG_CNT_W-1:0];
        REG_AT_MOST:   keep_at_most    <= cfg_data[CFG_CNT_W-1:0];
        REG_SELF_SIM:  self_similar    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rd_idx    <= '0;
      last_kept <= {1'b1, {(SCORE_W-1){1'b0}}};
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == OP_READ) begin
              state  <= ST_READ;
              rd_idx <= '0;
            end else if (!drop) begin
              count <= CNT_W'(cnt_mid);
              state <= ST_TRIM;
            end
          end
        end
        ST_TRIM: begin
          count <= CNT_W'(cnt_trim);
          if (cnt_trim != '0) begin
            last_kept <= trim_last;
          end
          state <= ST_IDLE;
        end
        ST_READ: begin
          if (load_out) begin
            if (count == '0) begin
              state <= ST_IDLE;
            end else if (rd_last) begin
              rd_idx <= '0;
              state  <= ST_IDLE;
            end else begin
              rd_idx <= rd_idx + CNT_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output valid: set when a result is loaded, drop once it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_READ && load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (state == ST_READ && load_out) begin
      if (count == '0) begin
        m_score  <= '0;
        m_query  <= '0;
        m_target <= '0;
        m_tuser  <= 1'b0;
        m_tlast  <= 1'b1;
      end else begin
        m_score  <= c_score[0];
        m_query  <= IDX_FIELD_W'(c_query[0]);
        m_target <= IDX_FIELD_W'(c_target[0]);
        m_tuser  <= 1'b1;
        m_tlast  <= rd_last;
      end
    end
  end

  assign m_tdata = {m_target, m_query, m_score};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(LIST_DEPTH))
    else $error("entry count above list depth");

  a_trim_after_offer: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TRIM) |-> $past(s_tvalid && s_tready && (s_tuser != OP_READ)))
    else $error("trim without an accepted offer");

  a_trim_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TRIM) |=> (count <= $past(count)))
    else $error("trim grew the list");

  a_read_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ && count != '0) |-> (rd_idx < count))
    else $error("read index beyond list length");

endmodule

[bench/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tslt_pkg::*;

  localparam int LIST_DEPTH = 32;
  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD = 400;

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_AT_LEAST  = 2'd1;
  localparam logic [1:0] REG_AT_MOST   = 2'd2;
  localparam logic [1:0] REG_SELF_SIM  = 2'd3;

  typedef struct packed {
    logic [SCORE_W-1:0]     score;
    logic [IDX_FIELD_W-1:0] query;
    logic [IDX_FIELD_W-1:0] target;
    logic                   valid;
    logic                   last;
  } entry_t;

  typedef enum logic [1:0] {ROW_OFFER, ROW_READ, ROW_CFG} row_kind_e;

  // reg_idx is only looked at on ROW_CFG rows; data is the score or the register value
  typedef struct packed {
    row_kind_e              kind;
    logic [1:0]             reg_idx;
    logic [31:0]            data;
    logic [IDX_FIELD_W-1:0] query;
    logic [IDX_FIELD_W-1:0] target;
    logic                   typed;
    entry_t                 want;
  } row_t;

  localparam entry_t NO_ENTRY   = '0;
  localparam entry_t EMPTY_READ = '{32'h0, 16'h0, 16'h0, 1'b0, 1'b1};
  localparam entry_t TOP_ONLY   = '{32'h7fffffff, 16'hffff, 16'hffff, 1'b1, 1'b1};

  localparam int NUM_DIRECTED = 26;
  localparam row_t DIRECTED [NUM_DIRECTED] = '{
    '{ROW_READ,  REG_THRESHOLD, 32'h0,        16'h0,    16'h0,    1'b1, EMPTY_READ},
    '{ROW_OFFER, REG_THRESHOLD, 32'h7fffffff, 16'hffff, 16'hffff, 1'b0, NO_ENTRY},
    '{ROW_READ,  REG_THRESHOLD, 32'h0,        16'h0,    16'h0,    1'b1, TOP_ONLY},
    '{ROW_OFFER, REG_THRESHOLD, 32'h80000000, 16'h0000, 16'h0000, 1'b0, NO_ENTRY},
    '{ROW_OFFER, REG_THRESHOLD, 32'h00000000, 16'h0001, 16'h0002, 1'b0, NO_ENTRY},
    // equal score lands ahead of the older entry
    '{ROW_OFFER, REG_THRESHOLD, 32'h00000000, 16'h0003, 16'h0004, 1'b0, NO_ENTRY},
    '{ROW_READ,  REG_THRESHOLD, 32'h0,        16'h0,    16'h0,    1'b0, NO_ENTRY},
    '{ROW_CFG,   REG_SELF_SIM,  32'h1,        16'h0,    16'h0,    1'b0, NO_ENTRY},
    '{ROW_OFFER, REG_THRESHOLD, 32'h00050000, 16'h0007, 16'h0007, 1'b0, NO_ENTRY},
    '{ROW_OFFER, REG_THRESHOLD, 32'h00050000, 16'h0003, 16'h0009, 1'b0, NO_ENTRY},
    '{ROW_OFFER, REG_THRESHOLD, 32'h00050000, 16'h0009, 16'h0003, 1'b0, NO_ENTRY},
    '{ROW_READ,  REG_THRESHOLD, 32'h0,        16'h0,    16'h0,    1'b0, NO_ENTRY},
    '{ROW_CFG,   REG_THRESHOLD, 32'h00010000, 16'h0,    16'h0,    1'b0, NO_ENTRY},
    '{ROW_CFG,   REG_AT_LEAST,  32'd2,        16'h0,    16'h0,    1'b0, NO_ENTRY},
    // below threshold but above the last kept score: goes in, then the tail is trimmed
    '{ROW_OFFER, REG_THRESHOLD, 32'h00008000, 16'haaaa, 16'h5555, 1'b0, NO_ENTRY},
    '{ROW_OFFER, REG_THRESHOLD, 32'hffffffff, 16'h8000, 16'h0001, 1'b0, NO_ENTRY},
    '{ROW_READ,  REG_THRESHOLD, 32'h0,        16'h0,    16'h0,    1'b0, NO_ENTRY},
    '{ROW_CFG,   REG_AT_MOST,   32'd0,        16'h0,    16'h0,    1'b0, NO_ENTRY},
    '{ROW_OFFER, REG_THRESHOLD, 32'h00020000, 16'h1234, 16'h0001, 1'b0, NO_ENTRY},
    '{ROW_READ,  REG_THRESHOLD, 32'h0,        16'h0,    16'h0,    1'b1, EMPTY_READ},
    '{ROW_CFG,   REG_AT_MOST,   32'd63,       16'h0,    16'h0,    1'b0, NO_ENTRY},
    '{ROW_CFG,   REG_AT_LEAST,  32'd40,       16'h0,    16'h0,    1'b0, NO_ENTRY},
    '{ROW_CFG,   REG_THRESHOLD, 32'h7fffffff, 16'h0,    16'h0,    1'b0, NO_ENTRY},
    '{ROW_CFG,   REG_SELF_SIM,  32'h0,        16'h0,    16'h0,    1'b0, NO_ENTRY},
    '{ROW_OFFER, REG_THRESHOLD, 32'h12345678, 16'h0000, 16'hffff, 1'b0, NO_ENTRY},
    '{ROW_READ,  REG_THRESHOLD, 32'h0,        16'h0,    16'h0,    1'b0, NO_ENTRY}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = OP_OFFER;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_THRESHOLD;
  logic [31:0] cfg_data = '0;

  top_score_list_with_threshold #(
    .LIST_DEPTH(LIST_DEPTH),
    .INDEX_BITS(IDX_FIELD_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // list image and register copies
  logic signed [SCORE_W-1:0] kept_score [LIST_DEPTH];
  logic [IDX_FIELD_W-1:0]    kept_query [LIST_DEPTH];
  logic [IDX_FIELD_W-1:0]    kept_target [LIST_DEPTH];
  int                        entry_count = 0;
  logic signed [SCORE_W-1:0] last_kept_score = 32'sh80000000;
  logic signed [SCORE_W-1:0] threshold_reg = 32'sh80000000;
  logic [CFG_CNT_W-1:0]      at_least_reg = 6'd1;
  logic [CFG_CNT_W-1:0]      at_most_reg = 6'd32;
  logic                      self_sim_reg = 1'b0;

  entry_t      expected_entries [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          tx_calm = 1'b0;
  logic        rx_calm = 1'b0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          rx_hold = 0;
  int          rx_wait = 0;

  function automatic void offer_entry(logic signed [SCORE_W-1:0] s,
                                      logic [IDX_FIELD_W-1:0] q,
                                      logic [IDX_FIELD_W-1:0] t);
    int pos;
    int k;
    int lim;
    if (self_sim_reg && q <= t) return;
    if (s < threshold_reg && s <= last_kept_score && entry_count >= int'(at_least_reg)) return;
    pos = entry_count;
    for (k = 0; k < entry_count; k++) begin
      if (kept_score[k] <= s) begin
        pos = k;
        break;
      end
    end
    if (pos < LIST_DEPTH) begin
      k = (entry_count < LIST_DEPTH) ? entry_count : LIST_DEPTH - 1;
      for (; k > pos; k--) begin
        kept_score[k]  = kept_score[k-1];
        kept_query[k]  = kept_query[k-1];
        kept_target[k] = kept_target[k-1];
      end
      kept_score[pos]  = s;
      kept_query[pos]  = q;
      kept_target[pos] = t;
      if (entry_count < LIST_DEPTH) entry_count++;
    end
    lim = (int'(at_most_reg) < LIST_DEPTH) ? int'(at_most_reg) : LIST_DEPTH;
    if (entry_count > lim) entry_count = lim;
    while (entry_count > int'(at_least_reg) && entry_count > 0 &&
           kept_score[entry_count-1] < threshold_reg)
      entry_count--;
    if (entry_count > 0) last_kept_score = kept_score[entry_count-1];
  endfunction

  function automatic void read_list();
    int k;
    if (entry_count == 0) begin
      expected_entries.push_back(EMPTY_READ);
      return;
    end
    for (k = 0; k < entry_count; k++)
      expected_entries.push_back('{kept_score[k], kept_query[k], kept_target[k], 1'b1,
                                   (k + 1 == entry_count)});
  endfunction

  function automatic logic [31:0] pick_score();
    int v;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: begin
        v = $urandom_range(0, 8);
        return (v - 4) * 65536;
      end
      3: return threshold_reg + $urandom_range(0, 4) - 2;
      4: return (entry_count > 0) ? kept_score[$urandom_range(0, entry_count - 1)] : $urandom();
      default: return {($urandom_range(0, 1) ? 16'hffff : 16'h0000), 16'($urandom())};
    endcase
  endfunction

  // handshake only; caller decides what to expect
  task automatic put_item(input logic op, input logic [31:0] data,
                          input logic [IDX_FIELD_W-1:0] q, input logic [IDX_FIELD_W-1:0] t);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {t, q, data};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_item(input logic op, input logic [31:0] data,
                           input logic [IDX_FIELD_W-1:0] q, input logic [IDX_FIELD_W-1:0] t);
    put_item(op, data, q, t);
    if (op == OP_OFFER) offer_entry(data, q, t);
    else read_list();
  endtask

  // drop valid, drain all results, then let a pending offer finish its trim cycle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD: threshold_reg = value;
      REG_AT_LEAST:  at_least_reg  = value[CFG_CNT_W-1:0];
      REG_AT_MOST:   at_most_reg   = value[CFG_CNT_W-1:0];
      REG_SELF_SIM:  self_sim_reg  = value[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [31:0] thr, input logic [31:0] least,
                           input logic [31:0] most, input logic self_sim, input int n_items,
                           input bit with_hold, input bit with_pause);
    logic [IDX_FIELD_W-1:0] q;
    logic [IDX_FIELD_W-1:0] t;
    int i;
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_AT_LEAST, least);
    write_reg(REG_AT_MOST, most);
    write_reg(REG_SELF_SIM, {31'b0, self_sim});
    for (i = 0; i < n_items; i++) begin
      // receiver freezes while items keep coming, so the block backs up once a read is sent
      if (with_hold && i == 8) hold_req <= hold_req + 1;
      if (with_pause && i == n_items / 2) wait_idle();
      if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
      if ($urandom_range(0, 15) == 0) rx_calm <= !rx_calm;
      q = $urandom();
      t = $urandom();
      case ($urandom_range(0, 4))
        0: t = q;
        1: q = t + 1'b1;
        2: begin
          q = $urandom_range(0, 1) ? '1 : '0;
          t = $urandom_range(0, 1) ? '1 : '0;
        end
        default: ;
      endcase
      // a read during the hold parks a result and stalls the input
      if ((with_hold && i == 9) || $urandom_range(0, 7) == 0)
        send_item(OP_READ, $urandom(), q, t);
      else send_item(OP_OFFER, pick_score(), q, t);
    end
  endtask

  // result receiver: random stall after each transaction, plus a long hold on request
  always @(posedge clk) begin
    int gap;
    gap = rx_calm ? 0 : $urandom_range(0, 18);
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      rx_hold   <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (m_tready && m_tvalid) begin
      rx_wait  <= gap;
      m_tready <= (gap == 0);
    end else if (!m_tready) begin
      if (rx_wait > 1) rx_wait <= rx_wait - 1;
      else m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    entry_t got;
    entry_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[31:0], m_tdata[47:32], m_tdata[63:48], m_tuser, m_tlast};
      if (expected_entries.size() == 0) begin
        $error("unexpected result transaction: %h", got);
        mismatches++;
      end else begin
        want = expected_entries.pop_front();
        if (got.score !== want.score) begin
          $error("entry_score: expected %h, got %h", want.score, got.score);
          mismatches++;
        end
        if (got.query !== want.query) begin
          $error("entry_query: expected %h, got %h", want.query, got.query);
          mismatches++;
        end
        if (got.target !== want.target) begin
          $error("entry_target: expected %h, got %h", want.target, got.target);
          mismatches++;
        end
        if (got.valid !== want.valid) begin
          $error("entry_valid: expected %b, got %b", want.valid, got.valid);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last_entry: expected %b, got %b", want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** top_score_list_with_threshold: FAILED **");
      $finish;
    end
  end

  initial begin
    int i;
    int v;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < NUM_DIRECTED; i++) begin
      case (DIRECTED[i].kind)
        ROW_CFG: write_reg(DIRECTED[i].reg_idx, DIRECTED[i].data);
        ROW_OFFER: send_item(OP_OFFER, DIRECTED[i].data, DIRECTED[i].query, DIRECTED[i].target);
        default: begin
          if (DIRECTED[i].typed) begin
            put_item(OP_READ, DIRECTED[i].data, DIRECTED[i].query, DIRECTED[i].target);
            expected_entries.push_back(DIRECTED[i].want);
          end else begin
            send_item(OP_READ, DIRECTED[i].data, DIRECTED[i].query, DIRECTED[i].target);
          end
        end
      endcase
    end

    // fill to the top with no trimming, then narrow and tighten the list
    tx_calm = 1'b1;
    run_phase(32'h7fffffff, 32'd40, 32'd63, 1'b0, 50, 1'b1, 1'b0);
    tx_calm = 1'b0;
    run_phase(32'h80000000, 32'd0, 32'd1, 1'b1, 30, 1'b0, 1'b0);
    run_phase(32'h00000000, 32'd32, 32'd32, 1'b0, 40, 1'b0, 1'b1);
    v = $urandom_range(0, 8);
    run_phase((v - 4) * 65536, $urandom_range(0, 8), $urandom_range(1, 32),
              $urandom_range(0, 1), 40, 1'b0, 1'b0);
    run_phase($urandom(), $urandom_range(0, 63), $urandom_range(0, 63),
              $urandom_range(0, 1), 40, 1'b0, 1'b0);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_entries.size() == 0) begin
      $display("** top_score_list_with_threshold: PASSED **");
    end else begin
      $display("** top_score_list_with_threshold: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
rtl/tslt_pkg.sv
rtl/tslt_cell.sv
rtl/top_score_list_with_threshold.sv
bench/testbench.sv
